// ----- hw/rtl/aris_pkg.sv -----
// Types and constants shared by the acoustic interface state pipeline.
`default_nettype none

package aris_pkg;

   typedef enum logic [1:0] {
      CSR_LIMITER       = 2'd0,
      CSR_INV_SOUND     = 2'd1,
      CSR_IMPEDANCE     = 2'd2,
      CSR_INV_IMPEDANCE = 2'd3
   } csr_index_type;

   localparam logic [31:0] LIMITER_RESET       = 32'd196608;
   localparam logic [31:0] INV_SOUND_RESET     = 32'd65536;
   localparam logic [31:0] IMPEDANCE_RESET     = 32'd65536;
   localparam logic [31:0] INV_IMPEDANCE_RESET = 32'd65536;

   localparam logic [16:0] MACH_ONE = 17'd65536;

   typedef struct packed {
      logic [30:0]        density_i;
      logic signed [31:0] pressure_i;
      logic signed [31:0] velocity_i_x;
      logic signed [31:0] velocity_i_y;
      logic [30:0]        density_j;
      logic signed [31:0] pressure_j;
      logic signed [31:0] velocity_j_x;
      logic signed [31:0] velocity_j_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
   } req_word_type;

   typedef struct packed {
      logic [30:0]        density_star;
      logic signed [31:0] pressure_star;
      logic signed [31:0] velocity_star_x;
      logic signed [31:0] velocity_star_y;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] limiter_coefficient;
      logic [31:0] inverse_mean_sound_speed;
      logic [31:0] impedance_geometric_mean;
      logic [31:0] inverse_impedance_mean;
   } cfg_type;

   // Averages and direction carried down the pipe until the pressure result is formed
   typedef struct packed {
      logic [30:0]        density_star;
      logic signed [31:0] pressure_avg;
      logic signed [31:0] velocity_avg_x;
      logic signed [31:0] velocity_avg_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
   } base_type;

   typedef struct packed {
      base_type           base;
      logic signed [35:0] jump;
      logic [47:0]        dp_scaled;
      logic               dp_neg;
   } front_type;

   typedef struct packed {
      base_type    base;
      logic [35:0] jump_mach;
      logic [16:0] mach_sq;
      logic [47:0] dp_scaled;
      logic        dp_neg;
   } mach_type;

endpackage

`default_nettype wire

// ----- hw/rtl/aris_front.sv -----
// Front stages: averages, velocity jump along the pair direction, scaled pressure jump.
`default_nettype none

module aris_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire aris_pkg::cfg_type    cfg,
   input  wire logic                 in_valid,
   output logic                      in_stall,
   input  wire aris_pkg::req_word_type in_word,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output aris_pkg::front_type       out_word
);

   typedef struct packed {
      aris_pkg::base_type base;
      logic signed [32:0] dv_x;
      logic signed [32:0] dv_y;
      logic signed [32:0] dp;
   } s1_type;

   typedef struct packed {
      aris_pkg::base_type base;
      logic signed [48:0] prod_x;
      logic signed [48:0] prod_y;
      logic [31:0]        dp_mag;
      logic               dp_neg;
   } s2_type;

   logic [2:0] valid_ff, valid_in;
   logic [2:0] en;

   s1_type              s1_ff, s1_in;
   s2_type              s2_ff, s2_in;
   aris_pkg::front_type s3_ff, s3_in;

   logic [31:0]        rho_sum;
   logic signed [32:0] p_sum, vx_sum, vy_sum;
   logic signed [32:0] dp_neg_val;
   logic signed [49:0] jump_sum, jump_q30;
   logic [63:0]        dp_prod;

   always_comb begin
      en[2] = !valid_ff[2] || !out_stall;
      en[1] = !valid_ff[1] || en[2];
      en[0] = !valid_ff[0] || en[1];
      valid_in[0] = en[0] ? in_valid    : valid_ff[0];
      valid_in[1] = en[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en[2] ? valid_ff[1] : valid_ff[2];
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[2];
   assign out_word  = s3_ff;

   // stage 1: sums and differences
   always_comb begin
      rho_sum = {1'b0, in_word.density_i} + {1'b0, in_word.density_j};
      p_sum   = 33'(in_word.pressure_i) + 33'(in_word.pressure_j);
      vx_sum  = 33'(in_word.velocity_i_x) + 33'(in_word.velocity_j_x);
      vy_sum  = 33'(in_word.velocity_i_y) + 33'(in_word.velocity_j_y);
      s1_in.base.density_star   = rho_sum[31:1];
      s1_in.base.pressure_avg   = p_sum[32:1];
      s1_in.base.velocity_avg_x = vx_sum[32:1];
      s1_in.base.velocity_avg_y = vy_sum[32:1];
      s1_in.base.dir_x          = in_word.dir_x;
      s1_in.base.dir_y          = in_word.dir_y;
      s1_in.dv_x = 33'(in_word.velocity_i_x) - 33'(in_word.velocity_j_x);
      s1_in.dv_y = 33'(in_word.velocity_i_y) - 33'(in_word.velocity_j_y);
      s1_in.dp   = 33'(in_word.pressure_i) - 33'(in_word.pressure_j);
   end

   // stage 2: direction products, pressure jump magnitude
   always_comb begin
      dp_neg_val    = -s1_ff.dp;
      s2_in.base    = s1_ff.base;
      s2_in.prod_x  = 49'(s1_ff.base.dir_x) * 49'(s1_ff.dv_x);
      s2_in.prod_y  = 49'(s1_ff.base.dir_y) * 49'(s1_ff.dv_y);
      s2_in.dp_neg  = s1_ff.dp[32];
      s2_in.dp_mag  = s1_ff.dp[32] ? dp_neg_val[31:0] : s1_ff.dp[31:0];
   end

   // stage 3: jump in Q20.16 (floored), pressure jump over impedance
   always_comb begin
      jump_sum        = 50'(s2_ff.prod_x) + 50'(s2_ff.prod_y);
      jump_q30        = -jump_sum;
      dp_prod         = 64'(s2_ff.dp_mag) * 64'(cfg.inverse_impedance_mean);
      s3_in.base      = s2_ff.base;
      s3_in.jump      = jump_q30[49:14];
      s3_in.dp_scaled = dp_prod[63:16];
      s3_in.dp_neg    = s2_ff.dp_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff <= s1_in;
      end
      if (en[1]) begin
         s2_ff <= s2_in;
      end
      if (en[2]) begin
         s3_ff <= s3_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/aris_mach.sv -----
// Middle stages: Mach factor from the velocity jump, limited and clamped to one.
`default_nettype none

module aris_mach (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire aris_pkg::cfg_type   cfg,
   input  wire logic                in_valid,
   output logic                     in_stall,
   input  wire aris_pkg::front_type in_word,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output aris_pkg::mach_type       out_word
);

   typedef struct packed {
      aris_pkg::base_type base;
      logic [34:0]        jump_mag;
      logic [32:0]        scaled;
      logic [47:0]        dp_scaled;
      logic               dp_neg;
   } s4_type;

   typedef struct packed {
      aris_pkg::base_type base;
      logic [34:0]        jump_mag;
      logic [16:0]        mach;
      logic [47:0]        dp_scaled;
      logic               dp_neg;
   } s5_type;

   logic [2:0] valid_ff, valid_in;
   logic [2:0] en;

   s4_type             s4_ff, s4_in;
   s5_type             s5_ff, s5_in;
   aris_pkg::mach_type s6_ff, s6_in;

   logic        jump_pos;
   logic [34:0] jump_mag;
   logic [66:0] t_prod;
   logic [64:0] m_prod;
   logic [51:0] w_prod;
   logic [32:0] sq_prod;

   always_comb begin
      en[2] = !valid_ff[2] || !out_stall;
      en[1] = !valid_ff[1] || en[2];
      en[0] = !valid_ff[0] || en[1];
      valid_in[0] = en[0] ? in_valid    : valid_ff[0];
      valid_in[1] = en[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en[2] ? valid_ff[1] : valid_ff[2];
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[2];
   assign out_word  = s6_ff;

   // stage 4: positive jump times inverse sound speed, saturated at 2^32
   always_comb begin
      jump_pos = !in_word.jump[35] && (in_word.jump != '0);
      jump_mag = jump_pos ? in_word.jump[34:0] : '0;
      t_prod   = 67'(jump_mag) * 67'(cfg.inverse_mean_sound_speed);
      s4_in.base      = in_word.base;
      s4_in.jump_mag  = jump_mag;
      s4_in.scaled    = (|t_prod[66:48]) ? {1'b1, 32'd0} : {1'b0, t_prod[47:16]};
      s4_in.dp_scaled = in_word.dp_scaled;
      s4_in.dp_neg    = in_word.dp_neg;
   end

   // stage 5: limiter scale, clamp to 1.0
   always_comb begin
      m_prod = 65'(cfg.limiter_coefficient) * 65'(s4_ff.scaled);
      s5_in.base      = s4_ff.base;
      s5_in.jump_mag  = s4_ff.jump_mag;
      s5_in.mach      = (m_prod[64:16] > 49'(aris_pkg::MACH_ONE)) ? aris_pkg::MACH_ONE
                                                                 : m_prod[32:16];
      s5_in.dp_scaled = s4_ff.dp_scaled;
      s5_in.dp_neg    = s4_ff.dp_neg;
   end

   // stage 6: jump times Mach, Mach squared
   always_comb begin
      w_prod  = 52'(s5_ff.jump_mag) * 52'(s5_ff.mach);
      sq_prod = 33'(s5_ff.mach) * 33'(s5_ff.mach);
      s6_in.base      = s5_ff.base;
      s6_in.jump_mach = w_prod[51:16];
      s6_in.mach_sq   = sq_prod[32:16];
      s6_in.dp_scaled = s5_ff.dp_scaled;
      s6_in.dp_neg    = s5_ff.dp_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s4_ff <= s4_in;
      end
      if (en[1]) begin
         s5_ff <= s5_in;
      end
      if (en[2]) begin
         s6_ff <= s6_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/aris_back.sv -----
// Back stages: pressure dissipation, velocity correction along e, saturation.
`default_nettype none

module aris_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire aris_pkg::cfg_type    cfg,
   input  wire logic                 in_valid,
   output logic                      in_stall,
   input  wire aris_pkg::mach_type   in_word,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output aris_pkg::rsp_word_type    out_word
);

   typedef struct packed {
      aris_pkg::base_type base;
      logic [50:0]        p_add;
      logic [47:0]        diss;
      logic               dp_neg;
   } s7_type;

   typedef struct packed {
      logic [30:0]        density_star;
      logic signed [31:0] pressure_star;
      logic signed [31:0] velocity_avg_x;
      logic signed [31:0] velocity_avg_y;
      logic signed [64:0] corr_x;
      logic signed [64:0] corr_y;
      logic               dp_neg;
   } s8_type;

   localparam logic signed [52:0] SAT_MAX = 53'sd2147483647;
   localparam logic signed [52:0] SAT_MIN = -53'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic [2:0] valid_ff, valid_in;
   logic [2:0] en;

   s7_type                 s7_ff, s7_in;
   s8_type                 s8_ff, s8_in;
   aris_pkg::rsp_word_type s9_ff, s9_in;

   logic [67:0]        d_prod;
   logic [64:0]        r_prod;
   logic signed [52:0] p_sum;
   logic signed [48:0] diss_s;
   logic signed [65:0] ux, uy;
   logic signed [52:0] vx, vy;

   always_comb begin
      en[2] = !valid_ff[2] || !out_stall;
      en[1] = !valid_ff[1] || en[2];
      en[0] = !valid_ff[0] || en[1];
      valid_in[0] = en[0] ? in_valid    : valid_ff[0];
      valid_in[1] = en[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en[2] ? valid_ff[1] : valid_ff[2];
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[2];
   assign out_word  = s9_ff;

   // stage 7: impedance term (halved), dissipation magnitude
   always_comb begin
      d_prod = 68'(in_word.jump_mach) * 68'(cfg.impedance_geometric_mean);
      r_prod = 65'(in_word.dp_scaled) * 65'(in_word.mach_sq);
      s7_in.base   = in_word.base;
      s7_in.p_add  = d_prod[67:17];
      s7_in.diss   = r_prod[64:17];
      s7_in.dp_neg = in_word.dp_neg;
   end

   // stage 8: pressure result, direction times dissipation
   always_comb begin
      p_sum  = 53'(s7_ff.base.pressure_avg) + $signed({2'b00, s7_ff.p_add});
      diss_s = $signed({1'b0, s7_ff.diss});
      s8_in.density_star   = s7_ff.base.density_star;
      s8_in.pressure_star  = sat32(p_sum);
      s8_in.velocity_avg_x = s7_ff.base.velocity_avg_x;
      s8_in.velocity_avg_y = s7_ff.base.velocity_avg_y;
      s8_in.corr_x = 65'(s7_ff.base.dir_x) * 65'(diss_s);
      s8_in.corr_y = 65'(s7_ff.base.dir_y) * 65'(diss_s);
      s8_in.dp_neg = s7_ff.dp_neg;
   end

   // stage 9: sign, floor by 2^14, subtract, saturate
   always_comb begin
      ux = s8_ff.dp_neg ? -66'(s8_ff.corr_x) : 66'(s8_ff.corr_x);
      uy = s8_ff.dp_neg ? -66'(s8_ff.corr_y) : 66'(s8_ff.corr_y);
      vx = 53'(s8_ff.velocity_avg_x) - 53'($signed(ux[65:14]));
      vy = 53'(s8_ff.velocity_avg_y) - 53'($signed(uy[65:14]));
      s9_in.density_star    = s8_ff.density_star;
      s9_in.pressure_star   = s8_ff.pressure_star;
      s9_in.velocity_star_x = sat32(vx);
      s9_in.velocity_star_y = sat32(vy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s7_ff <= s7_in;
      end
      if (en[1]) begin
         s8_ff <= s8_in;
      end
      if (en[2]) begin
         s9_ff <= s9_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/acoustic_riemann_interface_state_top.sv -----
// Top level of the acoustic interface state pipeline with its control registers.
`default_nettype none

// Nine-stage pipeline: one word per cycle in and out unless the response side stalls; a
// response word is registered in each stage after its request word is accepted, and is
// delayed further only by response stalls. The work is spread over the stages at roughly
// even depth; stall ripples back only through occupied stages, so empty slots are filled
// while a finished response waits. Control registers are read by the stages that use
// them, not held per word, and should be written only with the pipe empty.

module acoustic_riemann_interface_state_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire aris_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output aris_pkg::rsp_word_type      rsp_word,
   input  wire logic                   csr_wr_en,
   input  wire logic [1:0]             csr_index,
   input  wire logic [31:0]            csr_wr_data
);

   aris_pkg::cfg_type   cfg_ff, cfg_in;
   aris_pkg::front_type front_word;
   aris_pkg::mach_type  mach_word;
   logic                front_valid, front_stall;
   logic                mach_valid, mach_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (aris_pkg::csr_index_type'(csr_index))
            aris_pkg::CSR_LIMITER:       cfg_in.limiter_coefficient      = csr_wr_data;
            aris_pkg::CSR_INV_SOUND:     cfg_in.inverse_mean_sound_speed = csr_wr_data;
            aris_pkg::CSR_IMPEDANCE:     cfg_in.impedance_geometric_mean = csr_wr_data;
            aris_pkg::CSR_INV_IMPEDANCE: cfg_in.inverse_impedance_mean   = csr_wr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limiter_coefficient      <= aris_pkg::LIMITER_RESET;
         cfg_ff.inverse_mean_sound_speed <= aris_pkg::INV_SOUND_RESET;
         cfg_ff.impedance_geometric_mean <= aris_pkg::IMPEDANCE_RESET;
         cfg_ff.inverse_impedance_mean   <= aris_pkg::INV_IMPEDANCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   aris_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (req_word),
      .out_valid (front_valid),
      .out_stall (front_stall),
      .out_word  (front_word)
   );

   aris_mach u_mach (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_word   (front_word),
      .out_valid (mach_valid),
      .out_stall (mach_stall),
      .out_word  (mach_word)
   );

   aris_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mach_valid),
      .in_stall  (mach_stall),
      .in_word   (mach_word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

endmodule

`default_nettype wire

// ----- test/tb_acoustic_riemann_interface_state_top.sv -----
// Self-checking testbench for the acoustic interface state pipeline.
`default_nettype none

module tb_acoustic_riemann_interface_state_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   aris_pkg::req_word_type req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   aris_pkg::rsp_word_type rsp_word;
   logic                   csr_wr_en = 1'b0;
   logic [1:0]             csr_index = aris_pkg::CSR_LIMITER;
   logic [31:0]            csr_wr_data = '0;

   aris_pkg::cfg_type regs_model = '{aris_pkg::LIMITER_RESET, aris_pkg::INV_SOUND_RESET,
                                     aris_pkg::IMPEDANCE_RESET,
                                     aris_pkg::INV_IMPEDANCE_RESET};

   aris_pkg::req_word_type pair_queue[$];
   aris_pkg::rsp_word_type state_queue[$];
   int           words_outstanding = 0;
   int           error_count = 0;
   int           req_gap = 0;
   int           req_burst = 0;
   int           rsp_hold = 0;
   int           rsp_burst = 0;

   acoustic_riemann_interface_state_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // floor(a * b / 2^16)
   function automatic longint unsigned scale_q16(longint unsigned a, logic [31:0] b);
      return a * b[31:16] + ((a * b[15:0]) >> 16);
   endfunction

   function automatic logic [31:0] clamp_s32(longint v);
      if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return 32'(v);
   endfunction

   function automatic aris_pkg::rsp_word_type interface_state(aris_pkg::req_word_type w,
                                                              aris_pkg::cfg_type regs);
      aris_pkg::rsp_word_type res;
      longint unsigned rho_i, rho_j, ju, t, mach, wm, d, m2, a, q, r;
      longint          p_i, p_j, vix, viy, vjx, vjy, ex, ey;
      longint          p_avg, vx_avg, vy_avg, jump16, p_star, dp, u_diss;
      rho_i  = 64'(w.density_i);
      rho_j  = 64'(w.density_j);
      p_i    = 64'($signed(w.pressure_i));
      p_j    = 64'($signed(w.pressure_j));
      vix    = 64'($signed(w.velocity_i_x));
      viy    = 64'($signed(w.velocity_i_y));
      vjx    = 64'($signed(w.velocity_j_x));
      vjy    = 64'($signed(w.velocity_j_y));
      ex     = 64'($signed(w.dir_x));
      ey     = 64'($signed(w.dir_y));
      p_avg  = (p_i + p_j) >>> 1;
      vx_avg = (vix + vjx) >>> 1;
      vy_avg = (viy + vjy) >>> 1;
      jump16 = (-(ex * (vix - vjx) + ey * (viy - vjy))) >>> 14;
      mach   = 0;
      ju     = 0;
      if (jump16 > 0) begin
         ju = jump16;
         t  = scale_q16(ju, regs.inverse_mean_sound_speed);
         if (t > 64'hFFFF_FFFF) t = 64'h1_0000_0000;
         mach = (regs.limiter_coefficient * t) >> 16;
         if (mach > 65536) mach = 65536;
      end
      p_star = p_avg;
      if (mach != 0) begin
         wm     = (ju * mach) >> 16;
         d      = scale_q16(wm, regs.impedance_geometric_mean);
         p_star = p_avg + longint'(d >> 1);
      end
      m2 = (mach * mach) >> 16;
      dp = p_i - p_j;
      if (dp < 0) a = -dp;
      else a = dp;
      q = scale_q16(a, regs.inverse_impedance_mean);
      r = (q * m2) >> 17;
      u_diss = (dp < 0) ? -longint'(r) : longint'(r);
      res.density_star    = 31'((rho_i + rho_j) >> 1);
      res.pressure_star   = clamp_s32(p_star);
      res.velocity_star_x = clamp_s32(vx_avg - ((ex * u_diss) >>> 14));
      res.velocity_star_y = clamp_s32(vy_avg - ((ey * u_diss) >>> 14));
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] rand_q(int sc);
      case (sc)
         0:       return $urandom;
         1:       return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         2:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
      endcase
   endfunction

   function automatic logic [31:0] rand_reg();
      case ($urandom_range(0, 2))
         0:       return $urandom;
         1:       return $urandom_range(0, 32'h0004_0000);
         default: return $urandom_range(32'h0000_4000, 32'h0002_0000);
      endcase
   endfunction

   function automatic aris_pkg::req_word_type rand_item();
      aris_pkg::req_word_type w;
      int           sc;
      sc = $urandom_range(0, 3);
      w.density_i    = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                   : 31'($urandom_range(0, 32'h0040_0000));
      w.density_j    = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                   : 31'($urandom_range(0, 32'h0040_0000));
      w.pressure_i   = rand_q(sc);
      w.pressure_j   = rand_q(sc);
      w.velocity_i_x = rand_q(sc);
      w.velocity_i_y = rand_q(sc);
      w.velocity_j_x = rand_q(sc);
      w.velocity_j_y = rand_q(sc);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            case ($urandom_range(0, 3))
               0:       begin w.dir_x = 16'sd16384;  w.dir_y = 16'sd0;      end
               1:       begin w.dir_x = -16'sd16384; w.dir_y = 16'sd0;      end
               2:       begin w.dir_x = 16'sd0;      w.dir_y = 16'sd16384;  end
               default: begin w.dir_x = 16'sd0;      w.dir_y = -16'sd16384; end
            endcase
         end
         4, 5: begin
            w.dir_x = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
            w.dir_y = $urandom_range(0, 1) ? 16'sd11585 : -16'sd11585;
         end
         6, 7, 8: begin
            w.dir_x = 16'($urandom_range(0, 32768) - 16384);
            w.dir_y = 16'($urandom_range(0, 32768) - 16384);
         end
         default: begin
            w.dir_x = 16'($urandom);
            w.dir_y = 16'($urandom);
         end
      endcase
      return w;
   endfunction

   function automatic aris_pkg::req_word_type pair_item(
      logic [31:0] rho_i, logic [31:0] p_i, logic [31:0] vix, logic [31:0] viy,
      logic [31:0] rho_j, logic [31:0] p_j, logic [31:0] vjx, logic [31:0] vjy,
      logic [31:0] dx, logic [31:0] dy);
      aris_pkg::req_word_type w;
      w.density_i    = 31'(rho_i);
      w.pressure_i   = p_i;
      w.velocity_i_x = vix;
      w.velocity_i_y = viy;
      w.density_j    = 31'(rho_j);
      w.pressure_j   = p_j;
      w.velocity_j_x = vjx;
      w.velocity_j_y = vjy;
      w.dir_x        = 16'(dx);
      w.dir_y        = 16'(dy);
      return w;
   endfunction

   task automatic queue_item(aris_pkg::req_word_type w);
      pair_queue.push_back(w);
      words_outstanding++;
   endtask

   task automatic note_error(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_word(aris_pkg::rsp_word_type got);
      aris_pkg::rsp_word_type want;
      if (state_queue.size() == 0) begin
         note_error($sformatf("response word with nothing pending: %h", got));
      end else begin
         want = state_queue.pop_front();
         words_outstanding--;
         if (got.density_star !== want.density_star)
            note_error($sformatf("density_star %h, want %h",
                                 got.density_star, want.density_star));
         if (got.pressure_star !== want.pressure_star)
            note_error($sformatf("pressure_star %h, want %h",
                                 got.pressure_star, want.pressure_star));
         if (got.velocity_star_x !== want.velocity_star_x)
            note_error($sformatf("velocity_star_x %h, want %h",
                                 got.velocity_star_x, want.velocity_star_x));
         if (got.velocity_star_y !== want.velocity_star_y)
            note_error($sformatf("velocity_star_y %h, want %h",
                                 got.velocity_star_y, want.velocity_star_y));
      end
   endtask

   task automatic write_reg(aris_pkg::csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         aris_pkg::CSR_LIMITER:       regs_model.limiter_coefficient      = val;
         aris_pkg::CSR_INV_SOUND:     regs_model.inverse_mean_sound_speed = val;
         aris_pkg::CSR_IMPEDANCE:     regs_model.impedance_geometric_mean = val;
         aris_pkg::CSR_INV_IMPEDANCE: regs_model.inverse_impedance_mean   = val;
      endcase
   endtask

   task automatic set_regs(logic [31:0] lim, logic [31:0] inv_c, logic [31:0] z,
                           logic [31:0] inv_z);
      write_reg(aris_pkg::CSR_LIMITER, lim);
      write_reg(aris_pkg::CSR_INV_SOUND, inv_c);
      write_reg(aris_pkg::CSR_IMPEDANCE, z);
      write_reg(aris_pkg::CSR_INV_IMPEDANCE, inv_z);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (words_outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall)
            state_queue.push_back(interface_state(req_word, regs_model));
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pair_queue.size() != 0) begin
               req_word  <= pair_queue.pop_front();
               req_valid <= 1'b1;
               if (req_burst > 0) begin
                  req_burst--;
                  req_gap = 0;
               end else begin
                  req_gap = pick_gap();
                  if ($urandom_range(0, 49) == 0) req_burst = $urandom_range(20, 60);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_word(rsp_word);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if (rsp_burst > 0) begin
            rsp_burst--;
            rsp_stall <= 1'b0;
         end else begin
            rsp_hold = pick_gap();
            if ($urandom_range(0, 49) == 0) rsp_burst = $urandom_range(20, 60);
            rsp_stall <= (rsp_hold > 0);
            if (rsp_hold > 0) rsp_hold--;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_item(pair_item(0, 0, 0, 0, 0, 0, 0, 0, 16384, 0));
      queue_item(pair_item(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 16384));
      queue_item(pair_item(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                           2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, -16384));
      queue_item(pair_item(5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -16384, 0));
      // full Mach, pressure saturates upward
      queue_item(pair_item(100, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                           200, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16384, 0));
      queue_item(pair_item(100, 32'h8000_0000, 32'h8000_0000, 0,
                           200, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16384, 0));
      queue_item(pair_item(100, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           200, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, -16384, 16384));
      // jump below one unit
      queue_item(pair_item(7, 32'h0005_0000, 0, 0, 9, -32'h0003_0000, 1, 0, 8192, 0));
      // jump of exactly one unit
      queue_item(pair_item(7, 32'h0005_0000, 0, 0, 9, -32'h0003_0000, 1, 0, 16384, 0));
      // negative jump
      queue_item(pair_item(7, 32'h0005_0000, 32'h0001_0000, 0, 9, -32'h0003_0000, 0, 0,
                           16384, 0));
      // partial Mach factor
      queue_item(pair_item(65536, 32'h0005_0000, 0, 0, 131072, -32'h0003_0000, 0, 13107,
                           0, 16384));
      queue_item(pair_item(65536, -32'h0002_0000, 32'h0000_2000, 0, 131072, 32'h0004_0000,
                           0, 0, -16384, 0));
      queue_item(pair_item(3, 32'h0010_0000, 32'h0003_0000, -32'h0001_0000,
                           4, -32'h0010_0000, -32'h0002_0000, 32'h0005_0000,
                           32'h8000, 32'h8000));
      queue_item(pair_item(3, 32'h0010_0000, -32'h0000_1000, 32'h0000_0800,
                           4, -32'h0010_0000, 0, 0, 32'h7FFF, 32'h7FFF));
      queue_item(pair_item(3, 32'h0001_0000, -32'h0000_1000, 32'h0000_0800,
                           4, -32'h0001_0000, 0, 0, 11585, -11585));
      // odd negative sums round toward minus infinity
      queue_item(pair_item(1, -3, -3, -5, 2, 0, 0, 2, 0, 0));
      queue_item(pair_item(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                           32'h2AAA_AAAA, 32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555,
                           32'h5555, 32'hAAAA));
      repeat (80) queue_item(rand_item());
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       set_regs('0, '0, '0, '0);
            1:       set_regs('1, '1, '1, '1);
            5:       set_regs(aris_pkg::LIMITER_RESET, aris_pkg::INV_SOUND_RESET,
                              aris_pkg::IMPEDANCE_RESET, aris_pkg::INV_IMPEDANCE_RESET);
            default: set_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg());
         endcase
         repeat (70) queue_item(rand_item());
         drain();
      end

      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/aris_pkg.sv
hw/rtl/aris_front.sv
hw/rtl/aris_mach.sv
hw/rtl/aris_back.sv
hw/rtl/acoustic_riemann_interface_state_top.sv
test/tb_acoustic_riemann_interface_state_top.sv
